// File: rtl/asl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asl_pkg: shared types and constants
// Command codes, status codes and table sizing for the symbol layout table.
// ----------------------------------------------------------------------------
package asl_pkg;

	localparam int MaxSymbols = 64;
	localparam int IdxW = $clog2(MaxSymbols);
	localparam int CntW = $clog2(MaxSymbols + 1);

	localparam logic [2:0] CMD_ADD    = 3'd0;
	localparam logic [2:0] CMD_UPDATE = 3'd1;
	localparam logic [2:0] CMD_DELETE = 3'd2;
	localparam logic [2:0] CMD_XCHG   = 3'd3;
	localparam logic [2:0] CMD_ADDR   = 3'd4;
	localparam logic [2:0] CMD_SIZE   = 3'd5;
	localparam logic [2:0] CMD_SECT   = 3'd6;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_MISSING = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;

	// one table entry
	typedef struct packed {
		logic [31:0] id;
		logic [12:0] align;
		logic [23:0] size;
	} entry_t;

	// round up v to alignment a, zero alignment acts as one
	function automatic logic [31:0] round_up(input logic [31:0] v, input logic [12:0] a);
		logic [31:0] m;
		m = (a == 13'd0) ? 32'd0 : {19'd0, a - 13'd1};
		return (v + m) & ~m;
	endfunction

endpackage
`default_nettype wire

// File: rtl/aligned_symbol_layout_table.sv
`default_nettype none
// A command runs from accept to its result strobe; a command whose id is
// missing ends after its search. The table holds at most 64 entries.
// Throughput: one command at a time; busy stays high until the result strobe.
// Reset clears count, id counter, base address and control; the entry memory
// is not cleared. The receiver cannot stall: result is shown for one cycle.
// ----------------------------------------------------------------------------
// aligned_symbol_layout_table: ordered symbol table with layout lookups
// A sequencer walks the entry memory for search, shift, swap and layout sums.
// ----------------------------------------------------------------------------
module aligned_symbol_layout_table (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	output wire         cfg_ready,
	input  wire  [31:0] cfg_data,
	input  wire         start,
	output wire         busy,
	input  wire  [2:0]  cmd,
	input  wire  [31:0] id,
	input  wire  [31:0] other_id,
	input  wire  [12:0] align,
	input  wire  [23:0] size,
	output logic        done,
	output logic [1:0]  status,
	output logic [31:0] value
);
	import asl_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_FIND   = 4'd1;
	localparam logic [3:0] S_FIND2  = 4'd2;
	localparam logic [3:0] S_DECIDE = 4'd3;
	localparam logic [3:0] S_SHIFT  = 4'd4;
	localparam logic [3:0] S_SWAPA  = 4'd5;
	localparam logic [3:0] S_SWAPB  = 4'd6;
	localparam logic [3:0] S_LAYOUT = 4'd7;
	localparam logic [3:0] S_FINAL  = 4'd8;
	localparam logic [3:0] S_WRITE  = 4'd9;

	logic [3:0]       state_q;
	logic [2:0]       cmd_q;
	logic [31:0]      id_q, oid_q;
	logic [12:0]      align_q;
	logic [23:0]      size_q;
	logic [31:0]      base_q, idctr_q, acc_q;
	logic [CntW-1:0]  count_q, ptr_q, i_q, j_q, limit_q;
	logic             pend_q;  // a read is in flight for entry ptr_q-1
	logic             miss_q;  // an id search came up empty
	entry_t           ent_a_q;

	logic             we;
	logic [IdxW-1:0]  waddr, raddr;
	entry_t           wdata, rdata;

	asl_table_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
	);

	assign busy      = (state_q != S_IDLE);
	// a base write never lands together with a new command
	assign cfg_ready = !busy && !start;

	logic [CntW-1:0] prev;
	assign prev = ptr_q - CntW'(1);

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = prev[IdxW-1:0];
		wdata = rdata;
		raddr = ptr_q[IdxW-1:0];
		unique case (state_q)
			S_SHIFT: begin
				we    = pend_q;
				waddr = IdxW'(ptr_q - CntW'(2));
			end
			S_SWAPB: begin
				we    = pend_q;
				waddr = i_q[IdxW-1:0];
				wdata = rdata;
			end
			S_FINAL: begin
				we    = (cmd_q == CMD_XCHG) && !miss_q;
				waddr = j_q[IdxW-1:0];
				wdata = ent_a_q;
			end
			S_WRITE: begin
				we    = 1'b1;
				waddr = (cmd_q == CMD_ADD) ? count_q[IdxW-1:0] : i_q[IdxW-1:0];
				wdata.id    = (cmd_q == CMD_ADD) ? idctr_q : ent_a_q.id;
				wdata.align = align_q;
				wdata.size  = size_q;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idctr_q <= '0;
			base_q  <= '0;
			done    <= 1'b0;
			status  <= ST_DONE;
			value   <= '0;
			pend_q  <= 1'b0;
			miss_q  <= 1'b0;
			ptr_q   <= '0;
		end else begin
			done <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				base_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						id_q    <= id;
						oid_q   <= other_id;
						align_q <= align;
						size_q  <= size;
						ptr_q   <= '0;
						pend_q  <= 1'b0;
						miss_q  <= 1'b0;
						acc_q   <= base_q;
						if (cmd == CMD_ADD) begin
							state_q <= (count_q >= CntW'(MaxSymbols)) ? S_FINAL : S_WRITE;
						end else if (cmd == CMD_SECT) begin
							limit_q <= count_q;
							state_q <= S_LAYOUT;
						end else if (cmd == CMD_UPDATE || cmd == CMD_DELETE ||
							cmd == CMD_XCHG || cmd == CMD_ADDR || cmd == CMD_SIZE) begin
							i_q     <= count_q;
							state_q <= S_FIND;
						end else begin
							state_q <= S_FINAL;
						end
					end
				end
				// search for id: first hit in table order
				S_FIND: begin
					if (pend_q && rdata.id == id_q) begin
						i_q     <= prev;
						ent_a_q <= rdata;
						ptr_q   <= '0;
						pend_q  <= 1'b0;
						j_q     <= count_q;
						state_q <= (cmd_q == CMD_XCHG) ? S_FIND2 : S_DECIDE;
					end else if (ptr_q >= count_q) begin
						miss_q  <= 1'b1;
						state_q <= S_FINAL;
					end else begin
						ptr_q  <= ptr_q + CntW'(1);
						pend_q <= 1'b1;
					end
				end
				S_FIND2: begin
					if (pend_q && rdata.id == oid_q) begin
						j_q     <= prev;
						state_q <= S_DECIDE;
					end else if (ptr_q >= count_q) begin
						miss_q  <= 1'b1;
						state_q <= S_FINAL;
					end else begin
						ptr_q  <= ptr_q + CntW'(1);
						pend_q <= 1'b1;
					end
				end
				S_DECIDE: begin
					pend_q <= 1'b0;
					unique case (cmd_q)
						CMD_UPDATE: state_q <= S_WRITE;
						CMD_DELETE: begin
							ptr_q   <= i_q + CntW'(1);
							state_q <= S_SHIFT;
						end
						CMD_XCHG: begin
							ptr_q   <= j_q;
							state_q <= (i_q == j_q) ? S_FINAL : S_SWAPA;
						end
						CMD_ADDR: begin
							limit_q <= i_q;
							ptr_q   <= '0;
							state_q <= S_LAYOUT;
						end
						default: state_q <= S_FINAL;
					endcase
				end
				// move entries above the hole down by one
				S_SHIFT: begin
					if (ptr_q >= count_q) begin
						if (pend_q) begin
							pend_q <= 1'b0;
						end else begin
							count_q <= count_q - CntW'(1);
							state_q <= S_FINAL;
						end
						ptr_q <= (pend_q) ? ptr_q + CntW'(1) : ptr_q;
					end else begin
						ptr_q  <= ptr_q + CntW'(1);
						pend_q <= 1'b1;
					end
				end
				S_SWAPA: begin
					pend_q  <= 1'b1;
					state_q <= S_SWAPB;
				end
				S_SWAPB: state_q <= S_FINAL;
				// running layout sum, one entry a cycle
				S_LAYOUT: begin
					if (pend_q) begin
						acc_q <= round_up(acc_q, rdata.align) + {8'd0, rdata.size};
					end
					if (ptr_q >= limit_q) begin
						pend_q  <= 1'b0;
						ptr_q   <= i_q;
						state_q <= (pend_q || limit_q == '0) ? S_FINAL : S_LAYOUT;
					end else begin
						ptr_q  <= ptr_q + CntW'(1);
						pend_q <= 1'b1;
					end
				end
				S_WRITE: begin
					if (cmd_q == CMD_ADD) begin
						count_q <= count_q + CntW'(1);
						idctr_q <= idctr_q + 32'd1;
					end
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					done    <= 1'b1;
					state_q <= S_IDLE;
					status  <= ST_DONE;
					value   <= '0;
					if (cmd_q == CMD_ADD) begin
						if (ptr_q == CntW'(1)) begin
							value <= idctr_q - 32'd1;
						end else begin
							status <= ST_FULL;
						end
					end else if (cmd_q == CMD_SECT) begin
						value <= acc_q - base_q;
					end else if (miss_q) begin
						status <= ST_MISSING;
					end else if (cmd_q == CMD_ADDR) begin
						value <= round_up(acc_q, ent_a_q.align);
					end else if (cmd_q == CMD_SIZE) begin
						value <= {8'd0, ent_a_q.size};
					end
				end
				default: state_q <= S_IDLE;
			endcase
			// mark a successful add by ptr 1 for the final step
			if (state_q == S_WRITE) begin
				ptr_q <= CntW'(1);
			end
		end
	end

`ifndef SYNTH
	// a result strobe closes every command
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("strobe while busy");
	// the entry count never passes the table depth
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CntW'(MaxSymbols)) else $error("count overflow");
	// base address is held while a command runs
	a_base_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy && $past(busy) |-> $stable(base_q)) else $error("base changed");
`endif

endmodule
`default_nettype wire

// File: rtl/asl_table_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// asl_table_ram: entry storage
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module asl_table_ram (
	input  wire                        clk,
	input  wire                        we,
	input  wire  [asl_pkg::IdxW-1:0]   waddr,
	input  asl_pkg::entry_t            wdata,
	input  wire  [asl_pkg::IdxW-1:0]   raddr,
	output asl_pkg::entry_t            rdata
);
	import asl_pkg::*;

	entry_t mem_q [MaxSymbols];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire
